FILE: rtl/u2u_pkg.sv
// ----------------------------------------------------------------------------
// u2u_pkg
// Shared types and constants of the UTF-8 to UTF-16BE transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u2u_pkg;

    // Byte-order mark, sent first in every stream
    localparam logic [7:0] BOM_HI = 8'hFE;
    localparam logic [7:0] BOM_LO = 8'hFF;

    // Surrogate pair construction
    localparam logic [20:0] SUPP_BASE    = 21'h10000;
    localparam logic [15:0] SURR_HI_BASE = 16'hD800;
    localparam logic [15:0] SURR_LO_BASE = 16'hDC00;

    // Continuation bytes that follow each lead class
    localparam logic [1:0] CONT_NONE  = 2'd0;
    localparam logic [1:0] CONT_ONE   = 2'd1;
    localparam logic [1:0] CONT_TWO   = 2'd2;
    localparam logic [1:0] CONT_THREE = 2'd3;

    // Default depth of the job queue between front and back
    localparam int JOB_DEPTH_DEF = 4;

    // One queued job: what a single input word asks the back end to send
    typedef struct packed {
        logic        bom;       // send FE FF first
        logic        cp_valid;  // a code point is complete
        logic [20:0] cp;        // the code point
    } t_job;

endpackage

`default_nettype wire

FILE: rtl/u2u_front.sv
// ----------------------------------------------------------------------------
// u2u_front
// Accepts UTF-8 words, tracks the multi-byte sequence and turns each word
// that causes output into a job for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module u2u_front
    import u2u_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_start,
    output      logic       o_push,
    output      t_job       o_job
);

    logic [1:0]  r_rem, n_rem;
    logic [20:0] r_acc, n_acc;
    logic [1:0]  rem_cur;
    logic [20:0] acc_cur;
    logic [20:0] acc_shift;

    always_comb begin
        // a start drops any partial sequence
        rem_cur   = i_start ? CONT_NONE : r_rem;
        acc_cur   = i_start ? 21'd0 : r_acc;
        acc_shift = {acc_cur[14:0], i_data_byte[5:0]};

        n_rem          = rem_cur;
        n_acc          = acc_cur;
        o_job.bom      = i_start;
        o_job.cp_valid = 1'b0;
        o_job.cp       = 21'd0;

        if (rem_cur == CONT_NONE) begin
            if (!i_data_byte[7]) begin
                o_job.cp_valid = 1'b1;
                o_job.cp       = {13'd0, i_data_byte};
            end else if (!i_data_byte[5]) begin
                n_acc = {16'd0, i_data_byte[4:0]};
                n_rem = CONT_ONE;
            end else if (!i_data_byte[4]) begin
                n_acc = {17'd0, i_data_byte[3:0]};
                n_rem = CONT_TWO;
            end else begin
                n_acc = {18'd0, i_data_byte[2:0]};
                n_rem = CONT_THREE;
            end
        end else begin
            n_rem = rem_cur - 2'd1;
            n_acc = acc_shift;
            if (rem_cur == CONT_ONE) begin
                o_job.cp_valid = 1'b1;
                o_job.cp       = acc_shift;
                n_acc          = 21'd0;
            end
        end

        o_push = i_accept && (o_job.bom || o_job.cp_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= CONT_NONE;
            r_acc <= 21'd0;
        end else if (i_accept) begin
            r_rem <= n_rem;
            r_acc <= n_acc;
        end
    end

    // the accumulator is cleared whenever no sequence is open
    a_acc_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rem == CONT_NONE) |-> (r_acc == 21'd0))
        else $error("accumulator not clear between sequences");

    // a lead byte never finishes a code point unless it is plain ASCII
    a_lead_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && rem_cur == CONT_NONE && o_job.cp_valid) |-> (o_job.cp[20:7] == 14'd0))
        else $error("multi-byte lead produced a code point");

endmodule

`default_nettype wire

FILE: rtl/u2u_fifo.sv
// ----------------------------------------------------------------------------
// u2u_fifo
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module u2u_fifo
    import u2u_pkg::*;
#(
    parameter int DEPTH = JOB_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output      logic o_full,
    input  wire logic i_pop,
    output      logic o_valid,
    output      t_job o_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          push_ok, pop_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({push_ok, pop_ok})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job pushed into full queue");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

FILE: rtl/u2u_back.sv
// ----------------------------------------------------------------------------
// u2u_back
// Expands queued jobs into UTF-16BE output words, one byte per handshake,
// from a registered byte buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module u2u_back
    import u2u_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_job_valid,
    input  wire t_job       i_job,
    output      logic       o_pop,
    output      logic       o_tvalid,
    input  wire logic       i_tready,
    output      logic [7:0] o_tdata,
    output      logic       o_tlast
);

    logic            r_busy;
    logic [1:0]      r_idx;
    logic [1:0]      r_last;
    logic [3:0][7:0] r_bytes;
    logic [3:0][7:0] n_bytes;
    logic [1:0]      n_last;
    logic [20:0]     v;
    logic [15:0]     surr_hi, surr_lo;
    logic            out_fire, done;

    assign o_tvalid = r_busy;
    assign o_tdata  = r_bytes[r_idx];
    assign o_tlast  = (r_idx == r_last);
    assign out_fire = r_busy && i_tready;
    assign done     = out_fire && o_tlast;
    assign o_pop    = i_job_valid && (!r_busy || done);

    // lay out the bytes of the next job, first byte at index 0
    always_comb begin
        v       = i_job.cp - SUPP_BASE;
        surr_hi = {5'd0, v[20:10]} + SURR_HI_BASE;
        surr_lo = {6'd0, v[9:0]} + SURR_LO_BASE;
        n_bytes = '0;
        n_last  = 2'd1;
        if (i_job.bom) begin
            n_bytes[0] = BOM_HI;
            n_bytes[1] = BOM_LO;
            n_bytes[2] = i_job.cp[15:8];
            n_bytes[3] = i_job.cp[7:0];
            n_last     = i_job.cp_valid ? 2'd3 : 2'd1;
        end else if (i_job.cp[20:16] == 5'd0) begin
            n_bytes[0] = i_job.cp[15:8];
            n_bytes[1] = i_job.cp[7:0];
            n_last     = 2'd1;
        end else begin
            n_bytes[0] = surr_hi[15:8];
            n_bytes[1] = surr_hi[7:0];
            n_bytes[2] = surr_lo[15:8];
            n_bytes[3] = surr_lo[7:0];
            n_last     = 2'd3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bytes <= n_bytes;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (done) begin
            r_busy <= 1'b0;
        end else if (out_fire) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= r_last))
        else $error("byte index past end of job");

    a_pop_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (!r_busy || done))
        else $error("job loaded over unfinished job");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_tready) |=> (r_busy && $stable(r_idx)))
        else $error("stalled output word moved");

endmodule

`default_nettype wire

FILE: rtl/utf8_to_utf16be_stream.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16be_stream
// UTF-8 to UTF-16 big-endian byte transcoder with byte-order mark on start.
//
//  channel   dir  tdata (low bit up)   tuser / tlast
//  s_axis    in   data_byte[7:0]       tuser: start_of_stream
//  m_axis    out  out_byte[7:0]        tlast: last_of_run
//
// One input word per cycle is taken while the job queue has room; output is
// one byte per cycle while m_axis tready is high and jobs are queued, from
// the back end's registered byte buffer. The first byte of a word's job is
// offered once the job is written to the queue and then loaded into the
// buffer; jobs follow with no gap. A job is 2 or 4 bytes, so once the queue
// fills the output port sets the rate at which words are taken.
// Reset (synchronous, active low) clears the sequence state and the queue.
// Output stalls fill the queue (JOB_DEPTH jobs), then drop s_axis tready.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16be_stream
    import u2u_pkg::*;
#(
    parameter int JOB_DEPTH = JOB_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_axis_tvalid,
    output      logic       o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic       i_s_axis_tuser,   // [0] start_of_stream
    output      logic       o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output      logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output      logic       o_m_axis_tlast
);

    logic accept, push, full, job_valid, pop;
    t_job job_in, job_out;

    assign o_s_axis_tready = !full;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    u2u_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_s_axis_tdata),
        .i_start     (i_s_axis_tuser),
        .o_push      (push),
        .o_job       (job_in)
    );

    u2u_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_job   (job_out)
    );

    u2u_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job_out),
        .o_pop       (pop),
        .o_tvalid    (o_m_axis_tvalid),
        .i_tready    (i_m_axis_tready),
        .o_tdata     (o_m_axis_tdata),
        .o_tlast     (o_m_axis_tlast)
    );

endmodule

`default_nettype wire
